[hw/rtl/agmr_pkg.sv]
// Shared types and constants for the affine gradient moment reduction block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package agmr_pkg;

    // Configuration register file.
    localparam int CFG_WIDTH     = 13;
    localparam int CFG_IDX_WIDTH = 1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GRID_HEIGHT = 1'b1;
    localparam logic [CFG_WIDTH-1:0]     GRID_DIM_RESET  = 13'd256;

    // Moment sums.
    localparam int SUM_WIDTH = 64;
    localparam int NUM_SUMS  = 6;
    localparam int SUM_X_GX  = 0;
    localparam int SUM_Y_GX  = 1;
    localparam int SUM_GX    = 2;
    localparam int SUM_X_GY  = 3;
    localparam int SUM_Y_GY  = 4;
    localparam int SUM_GY    = 5;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_WIDTH = 2;
    localparam int QUEUE_CNT_WIDTH = 3;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

[hw/rtl/agmr_front.sv]
// Front part: holds the grid size registers and the column and row counters,
// tags each accepted pixel with its coordinates and an end-of-frame flag.
// Depends on agmr_pkg.
`default_nettype none

module agmr_front #(
    parameter int MAX_DIM    = 4096,
    parameter int GRAD_WIDTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [agmr_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_addr,
    input  wire logic [agmr_pkg::CFG_WIDTH-1:0]        i_cfg_wdata,
    input  wire logic                                  i_accept,
    input  wire logic [GRAD_WIDTH-1:0]                 i_grad_x,
    input  wire logic [GRAD_WIDTH-1:0]                 i_grad_y,
    // Fields from the lowest bit up: grad_x, grad_y, column, row, last.
    output logic [2*GRAD_WIDTH+2*$clog2(MAX_DIM):0]    o_item
);

    localparam int CW   = $clog2(MAX_DIM);
    localparam int DW   = CW + 1;
    localparam int CMPW = (agmr_pkg::CFG_WIDTH > DW) ? agmr_pkg::CFG_WIDTH : DW;

    logic [agmr_pkg::CFG_WIDTH-1:0] r_grid_width;
    logic [agmr_pkg::CFG_WIDTH-1:0] r_grid_height;
    logic [CW-1:0]                  r_col;
    logic [CW-1:0]                  r_row;
    logic [CW-1:0]                  n_col;
    logic [CW-1:0]                  n_row;
    logic [DW-1:0]                  eff_width;
    logic [DW-1:0]                  eff_height;
    logic                           last_col;
    logic                           last_row;

    function automatic logic [DW-1:0] clamp_dim(input logic [agmr_pkg::CFG_WIDTH-1:0] v);
        logic [CMPW-1:0] ext;
        ext = CMPW'(v);
        if (ext == '0) begin
            clamp_dim = DW'(1);
        end else if (ext > CMPW'(MAX_DIM)) begin
            clamp_dim = DW'(MAX_DIM);
        end else begin
            clamp_dim = DW'(ext);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= agmr_pkg::GRID_DIM_RESET;
            r_grid_height <= agmr_pkg::GRID_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                agmr_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata;
                agmr_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign eff_width  = clamp_dim(r_grid_width);
    assign eff_height = clamp_dim(r_grid_height);

    // A shrunken grid can leave a counter beyond its new end, hence >= here.
    assign last_col = ({1'b0, r_col} + DW'(1)) >= eff_width;
    assign last_row = ({1'b0, r_row} + DW'(1)) >= eff_height;

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : r_row + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_item = {last_col & last_row, r_row, r_col, i_grad_y, i_grad_x};

endmodule

`default_nettype wire

[hw/rtl/agmr_queue.sv]
// Short register queue that decouples the front part from the back part.
// Depends on agmr_pkg for its depth and status struct.
`default_nettype none

module agmr_queue #(
    parameter int WIDTH = 57
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [WIDTH-1:0]  i_data,
    input  wire logic              i_pop,
    output logic [WIDTH-1:0]       o_data,
    output agmr_pkg::t_queue_status o_status
);

    logic [WIDTH-1:0]                       r_mem [agmr_pkg::QUEUE_DEPTH];
    logic [agmr_pkg::QUEUE_PTR_WIDTH-1:0]   r_wr_ptr;
    logic [agmr_pkg::QUEUE_PTR_WIDTH-1:0]   r_rd_ptr;
    logic [agmr_pkg::QUEUE_CNT_WIDTH-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + agmr_pkg::QUEUE_PTR_WIDTH'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + agmr_pkg::QUEUE_PTR_WIDTH'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + agmr_pkg::QUEUE_CNT_WIDTH'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - agmr_pkg::QUEUE_CNT_WIDTH'(1);
            end
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == agmr_pkg::QUEUE_CNT_WIDTH'(agmr_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

`default_nettype wire

[hw/rtl/agmr_back.sv]
// Back part: multiplies the coordinates by the gradients in one stage and
// accumulates the six moment sums in the next, loading the result register
// at the end of each frame. Depends on agmr_pkg.
`default_nettype none

module agmr_back #(
    parameter int MAX_DIM    = 4096,
    parameter int GRAD_WIDTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire agmr_pkg::t_queue_status               i_q_status,
    input  wire logic [2*GRAD_WIDTH+2*$clog2(MAX_DIM):0] i_item,
    output logic                                       o_pop,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [agmr_pkg::NUM_SUMS*agmr_pkg::SUM_WIDTH-1:0] o_data
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int PW = CW + 1 + GRAD_WIDTH;
    localparam int SW = agmr_pkg::SUM_WIDTH;

    logic signed [GRAD_WIDTH-1:0] gx;
    logic signed [GRAD_WIDTH-1:0] gy;
    logic signed [CW:0]           x_s;
    logic signed [CW:0]           y_s;
    logic                         item_last;

    logic                         r_s1_valid;
    logic                         r_s1_last;
    logic signed [PW-1:0]         r_p_xgx;
    logic signed [PW-1:0]         r_p_ygx;
    logic signed [PW-1:0]         r_p_xgy;
    logic signed [PW-1:0]         r_p_ygy;
    logic signed [GRAD_WIDTH-1:0] r_s1_gx;
    logic signed [GRAD_WIDTH-1:0] r_s1_gy;
    logic                         s1_adv;

    logic [SW-1:0] r_sum [agmr_pkg::NUM_SUMS];
    logic [SW-1:0] n_sum [agmr_pkg::NUM_SUMS];
    logic [SW-1:0] r_out [agmr_pkg::NUM_SUMS];
    logic [SW-1:0] addend [agmr_pkg::NUM_SUMS];
    logic          r_out_valid;

    assign gx        = i_item[GRAD_WIDTH-1:0];
    assign gy        = i_item[2*GRAD_WIDTH-1:GRAD_WIDTH];
    assign x_s       = {1'b0, i_item[2*GRAD_WIDTH+CW-1:2*GRAD_WIDTH]};
    assign y_s       = {1'b0, i_item[2*GRAD_WIDTH+2*CW-1:2*GRAD_WIDTH+CW]};
    assign item_last = i_item[2*GRAD_WIDTH+2*CW];

    // The product stage holds a frame's last pixel until the result register is free.
    assign s1_adv = r_s1_valid && (!r_s1_last || !r_out_valid || i_ready);
    assign o_pop  = !i_q_status.empty && (!r_s1_valid || s1_adv);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_xgx   <= x_s * gx;
            r_p_ygx   <= y_s * gx;
            r_p_xgy   <= x_s * gy;
            r_p_ygy   <= y_s * gy;
            r_s1_gx   <= gx;
            r_s1_gy   <= gy;
            r_s1_last <= item_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_pop) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_comb begin
        addend[agmr_pkg::SUM_X_GX] = {{(SW-PW){r_p_xgx[PW-1]}}, r_p_xgx};
        addend[agmr_pkg::SUM_Y_GX] = {{(SW-PW){r_p_ygx[PW-1]}}, r_p_ygx};
        addend[agmr_pkg::SUM_GX]   = {{(SW-GRAD_WIDTH){r_s1_gx[GRAD_WIDTH-1]}}, r_s1_gx};
        addend[agmr_pkg::SUM_X_GY] = {{(SW-PW){r_p_xgy[PW-1]}}, r_p_xgy};
        addend[agmr_pkg::SUM_Y_GY] = {{(SW-PW){r_p_ygy[PW-1]}}, r_p_ygy};
        addend[agmr_pkg::SUM_GY]   = {{(SW-GRAD_WIDTH){r_s1_gy[GRAD_WIDTH-1]}}, r_s1_gy};
        for (int k = 0; k < agmr_pkg::NUM_SUMS; k++) begin
            n_sum[k] = r_sum[k] + addend[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < agmr_pkg::NUM_SUMS; k++) begin
                r_sum[k] <= '0;
            end
        end else if (s1_adv) begin
            for (int k = 0; k < agmr_pkg::NUM_SUMS; k++) begin
                r_sum[k] <= r_s1_last ? '0 : n_sum[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last) begin
            for (int k = 0; k < agmr_pkg::NUM_SUMS; k++) begin
                r_out[k] <= n_sum[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    for (genvar g = 0; g < agmr_pkg::NUM_SUMS; g++) begin : g_pack
        assign o_data[g*SW +: SW] = r_out[g];
    end

endmodule

`default_nettype wire

[hw/rtl/affine_gradient_moment_reduction_top.sv]
// A frame's result passes the queue, product stage and result register after its
// last pixel is accepted. Throughput: one pixel per cycle; the product stage holds
// only a frame's last pixel while the previous result waits at the output register.
// Reset (synchronous, active low) sets the grid to 256 x 256, clears the
// counters, sums, queue and output valid. Top level; depends on agmr_pkg,
// agmr_front, agmr_queue and agmr_back.
`default_nettype none

module affine_gradient_moment_reduction_top #(
    parameter int MAX_DIM    = 4096,
    parameter int GRAD_WIDTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [agmr_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_addr,
    input  wire logic [agmr_pkg::CFG_WIDTH-1:0]       i_cfg_wdata,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // Fields from the lowest bit up: grad_x, grad_y, zero padding to bytes.
    input  wire logic [((2*GRAD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // Fields from the lowest bit up: sum_x_times_gx, sum_y_times_gx, sum_gx,
    // sum_x_times_gy, sum_y_times_gy, sum_gy.
    output logic [agmr_pkg::NUM_SUMS*agmr_pkg::SUM_WIDTH-1:0] m_axis_tdata
);

    localparam int CW     = $clog2(MAX_DIM);
    localparam int ITEM_W = 2*GRAD_WIDTH + 2*CW + 1;

    logic                    in_accept;
    logic [ITEM_W-1:0]       front_item;
    logic [ITEM_W-1:0]       queue_item;
    logic                    queue_pop;
    agmr_pkg::t_queue_status queue_status;

    assign s_axis_tready = !queue_status.full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    agmr_front #(
        .MAX_DIM    (MAX_DIM),
        .GRAD_WIDTH (GRAD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_grad_x    (s_axis_tdata[GRAD_WIDTH-1:0]),
        .i_grad_y    (s_axis_tdata[2*GRAD_WIDTH-1:GRAD_WIDTH]),
        .o_item      (front_item)
    );

    agmr_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_data   (front_item),
        .i_pop    (queue_pop),
        .o_data   (queue_item),
        .o_status (queue_status)
    );

    agmr_back #(
        .MAX_DIM    (MAX_DIM),
        .GRAD_WIDTH (GRAD_WIDTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (queue_status),
        .i_item     (queue_item),
        .o_pop      (queue_pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

`default_nettype wire

[verif/affine_gradient_moment_reduction_top_tb.sv]
// Self-checking testbench for affine_gradient_moment_reduction_top. It streams
// gradient pixels through many grid sizes and checks every frame's six moment sums.
// Depends on agmr_pkg and the block's RTL; needs no files or arguments.
`default_nettype none

module affine_gradient_moment_reduction_top_tb;

    localparam int GRAD_W        = 16;
    localparam int MAX_DIM       = 4096;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 1350;
    localparam int OPEN_PIXELS   = 64;
    localparam int LONG_HOLD     = 60;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gy;
        logic signed [GRAD_W-1:0] gx;
    } t_pixel;

    typedef logic [agmr_pkg::NUM_SUMS-1:0][agmr_pkg::SUM_WIDTH-1:0] t_moments;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_cfg_we      = 1'b0;
    logic [agmr_pkg::CFG_IDX_WIDTH-1:0] i_cfg_addr    = '0;
    logic [agmr_pkg::CFG_WIDTH-1:0]     i_cfg_wdata   = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    // Fields from the lowest bit up: grad_x, grad_y.
    logic [2*GRAD_W-1:0]                s_axis_tdata  = '0;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // Fields from the lowest bit up: sum_x_times_gx, sum_y_times_gx, sum_gx,
    // sum_x_times_gy, sum_y_times_gy, sum_gy.
    t_moments                           m_axis_tdata;

    // Predicted state of the block.
    logic [agmr_pkg::CFG_WIDTH-1:0] grid_w_reg      = agmr_pkg::GRID_DIM_RESET;
    logic [agmr_pkg::CFG_WIDTH-1:0] grid_h_reg      = agmr_pkg::GRID_DIM_RESET;
    logic [11:0]                    col_idx         = '0;
    logic [11:0]                    row_idx         = '0;
    t_moments                       running_moments = '0;

    t_pixel      pixel_q[$];
    t_moments    frame_sums_q[$];
    int unsigned pixels_issued   = 0;
    int unsigned pixels_accepted = 0;
    int unsigned frames_checked  = 0;
    int unsigned grid_settings   = 0;
    int unsigned error_count     = 0;
    int unsigned tx_idle_pct     = 19;
    int unsigned rx_idle_pct     = 73;
    int unsigned hold_left       = 0;
    logic        hold_trigger    = 1'b0;

    affine_gradient_moment_reduction_top #(
        .MAX_DIM    (MAX_DIM),
        .GRAD_WIDTH (GRAD_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // A register value of zero acts as one, and anything above the maximum as the maximum.
    function automatic int effective_dim(int v);
        if (v < 1) begin
            return 1;
        end
        if (v > MAX_DIM) begin
            return MAX_DIM;
        end
        return v;
    endfunction

    function automatic string sum_name(int k);
        case (k)
            agmr_pkg::SUM_X_GX: return "sum_x_times_gx";
            agmr_pkg::SUM_Y_GX: return "sum_y_times_gx";
            agmr_pkg::SUM_GX:   return "sum_gx";
            agmr_pkg::SUM_X_GY: return "sum_x_times_gy";
            agmr_pkg::SUM_Y_GY: return "sum_y_times_gy";
            default:            return "sum_gy";
        endcase
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endfunction

    // Adds one pixel's moments and advances the raster position; a completed
    // frame queues its sums and clears them.
    function automatic void accumulate_pixel(t_pixel p);
        longint gx;
        longint gy;
        longint x;
        longint y;
        gx = p.gx;
        gy = p.gy;
        x  = col_idx;
        y  = row_idx;
        running_moments[agmr_pkg::SUM_X_GX] += x * gx;
        running_moments[agmr_pkg::SUM_Y_GX] += y * gx;
        running_moments[agmr_pkg::SUM_GX]   += gx;
        running_moments[agmr_pkg::SUM_X_GY] += x * gy;
        running_moments[agmr_pkg::SUM_Y_GY] += y * gy;
        running_moments[agmr_pkg::SUM_GY]   += gy;
        // Counters survive a size change, so a row or frame ends at or beyond the bound.
        if (int'(col_idx) + 1 < effective_dim(grid_w_reg)) begin
            col_idx = col_idx + 1'b1;
        end else begin
            col_idx = '0;
            if (int'(row_idx) + 1 < effective_dim(grid_h_reg)) begin
                row_idx = row_idx + 1'b1;
            end else begin
                frame_sums_q.push_back(running_moments);
                row_idx         = '0;
                running_moments = '0;
            end
        end
    endfunction

    function automatic void check_frame(t_moments got);
        t_moments want;
        if (frame_sums_q.size() == 0) begin
            note_error($sformatf("unexpected result %h", got));
        end else begin
            want = frame_sums_q.pop_front();
            frames_checked++;
            for (int k = 0; k < agmr_pkg::NUM_SUMS; k++) begin
                if (got[k] !== want[k]) begin
                    note_error($sformatf("frame %0d %s: expected %0d, got %0d", frames_checked,
                        sum_name(k), $signed(want[k]), $signed(got[k])));
                end
            end
        end
    endfunction

    function automatic t_pixel make_pixel(logic [GRAD_W-1:0] gx, logic [GRAD_W-1:0] gy);
        t_pixel p;
        p.gx = gx;
        p.gy = gy;
        return p;
    endfunction

    function automatic logic [GRAD_W-1:0] random_grad();
        case ($urandom_range(9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return $urandom_range(1) ? 16'hffff : 16'h0001;
            3, 4:    return 16'($urandom_range(600)) - 16'd300;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        return make_pixel(random_grad(), random_grad());
    endfunction

    task automatic send_pixel(t_pixel p);
        pixel_q.push_back(p);
        pixels_issued++;
    endtask

    // Waits until every pixel is taken and every frame result has arrived, then
    // lets the pipeline drain.
    task automatic wait_idle();
        while (pixels_accepted != pixels_issued || frame_sums_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [agmr_pkg::CFG_IDX_WIDTH-1:0] idx,
                             logic [agmr_pkg::CFG_WIDTH-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        if (idx == agmr_pkg::REG_GRID_WIDTH) begin
            grid_w_reg = val;
        end else begin
            grid_h_reg = val;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_grid(int w, int h);
        write_reg(agmr_pkg::REG_GRID_WIDTH, agmr_pkg::CFG_WIDTH'(w));
        write_reg(agmr_pkg::REG_GRID_HEIGHT, agmr_pkg::CFG_WIDTH'(h));
        grid_settings++;
    endtask

    // Ends whatever frame is open so the next frame starts at the origin.
    task automatic close_frame();
        set_grid(0, 0);
        send_pixel(random_pixel());
        wait_idle();
    endtask

    // Pixel driver: holds each request until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                accumulate_pixel(t_pixel'(s_axis_tdata));
                pixels_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_axis_tdata  <= pixel_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure and an occasional long hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_frame(m_axis_tdata);
            end
            if (hold_trigger) begin
                hold_left <= LONG_HOLD;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
            m_axis_tready <= !hold_trigger && (hold_left < 2) &&
                             ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin : stimulus
        int unsigned random_sent;
        int unsigned target;
        int          w;
        int          h;
        int          n;
        random_sent = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Extremes under the reset grid; the frame stays open.
        send_pixel(make_pixel(16'h7fff, 16'h8000));
        send_pixel(make_pixel(16'h8000, 16'h7fff));
        send_pixel(make_pixel(16'h0000, 16'h0000));
        send_pixel(make_pixel(16'hffff, 16'hffff));
        send_pixel(make_pixel(16'h5555, 16'haaaa));
        wait_idle();

        // Shrink the grid while the column count is already past the new width.
        set_grid(3, 2);
        repeat (4) send_pixel(random_pixel());
        send_pixel(make_pixel(16'h7fff, 16'h7fff));
        send_pixel(make_pixel(16'h8000, 16'h8000));
        send_pixel(make_pixel(16'h7fff, 16'h8000));
        send_pixel(make_pixel(16'h8000, 16'h7fff));
        send_pixel(make_pixel(16'haaaa, 16'h5555));
        send_pixel(make_pixel(16'h0001, 16'hffff));
        wait_idle();

        // Zero-sized grid acts as one pixel per frame; hold the output long
        // enough that the block backs up and stops taking pixels.
        set_grid(0, 0);
        @(posedge i_clk);
        hold_trigger <= 1'b1;
        repeat (10) send_pixel(random_pixel());
        @(posedge i_clk);
        hold_trigger <= 1'b0;

        for (int mode = 0; mode < 3; mode++) begin
            wait_idle();
            tx_idle_pct <= (mode == 0) ? 19 : (mode == 1) ? 73 : 0;
            rx_idle_pct <= (mode == 0) ? 73 : (mode == 1) ? 19 : 0;
            if (mode == 1) begin
                // All-ones width clamps to the widest row; the frame is left
                // open so the next smaller grid ends it.
                close_frame();
                set_grid(8191, 1);
                repeat (OPEN_PIXELS) send_pixel(random_pixel());
            end else if (mode == 2) begin
                close_frame();
                set_grid(1, 8191);
                repeat (OPEN_PIXELS) send_pixel(random_pixel());
            end
            target = (mode + 1) * RANDOM_PIXELS / 3;
            while (random_sent < target) begin
                wait_idle();
                w = $urandom_range(9);
                h = $urandom_range(6);
                set_grid(w, h);
                n = effective_dim(w) * effective_dim(h) * $urandom_range(1, 4);
                // Sometimes leave a frame open across the next size change.
                if ($urandom_range(3) == 0) begin
                    n += $urandom_range(effective_dim(w));
                end
                repeat (n) send_pixel(random_pixel());
                random_sent += n;
            end
        end

        wait_idle();
        $display("Streamed %0d pixels and checked %0d frame results over %0d grid settings,",
                 pixels_accepted, frames_checked, grid_settings);
        $display("including clamped sizes, frames left open across size changes and a long stall.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Timeout with %0d frame results outstanding", frame_sums_q.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
